// File: design/lkd_pkg.sv
// lkd_pkg: shared types and constants for the ladder keypad debounce block
// item kinds, key codes, register indexes and reset values of the thresholds
// no dependencies
`timescale 1ns / 1ps

package lkd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CODE_W     = 3;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_LADDER = 4;
    localparam int NUM_KEYS   = 5;

    // kind of an input item
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_SCAN   = 2'd2
    } kind_t;

    // reported key codes
    localparam logic [CODE_W-1:0] KEY_NONE = 3'd0;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEFT_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_LOW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DOWN_LOW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DOWN_HIGH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_UP_LOW     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_UP_HIGH    = 3'd6;

    // threshold set
    typedef struct packed {
        logic [SAMPLE_W-1:0] left_min;
        logic [SAMPLE_W-1:0] right_low;
        logic [SAMPLE_W-1:0] right_high;
        logic [SAMPLE_W-1:0] down_low;
        logic [SAMPLE_W-1:0] down_high;
        logic [SAMPLE_W-1:0] up_low;
        logic [SAMPLE_W-1:0] up_high;
    } lkd_cfg_t;

    localparam lkd_cfg_t CFG_RESET = '{
        left_min:   12'd3723,
        right_low:  12'd1737,
        right_high: 12'd2234,
        down_low:   12'd1241,
        down_high:  12'd1613,
        up_low:     12'd744,
        up_high:    12'd1179
    };

    // one item handed from the input register to the key logic
    typedef struct packed {
        logic                step;
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample;
        logic                ok_level;
    } lkd_item_t;

endpackage

// File: design/lkd_classify.sv
// lkd_classify: sorts one ladder reading into the four key windows
// depends on lkd_pkg
`timescale 1ns / 1ps

module lkd_classify (
    input  lkd_pkg::lkd_cfg_t                  cfg,
    input  logic [lkd_pkg::SAMPLE_W-1:0]        sample,
    output logic [lkd_pkg::NUM_LADDER-1:0]      hit
);
    import lkd_pkg::*;

    logic is_left;
    logic is_right;
    logic is_down;
    logic is_up;

    // strict windows, earlier key wins on overlap
    always_comb begin
        is_left  = sample > cfg.left_min;
        is_right = (sample > cfg.right_low) && (sample < cfg.right_high);
        is_down  = (sample > cfg.down_low) && (sample < cfg.down_high);
        is_up    = (sample > cfg.up_low) && (sample < cfg.up_high);
        hit[0] = is_left;
        hit[1] = !is_left && is_right;
        hit[2] = !is_left && !is_right && is_down;
        hit[3] = !is_left && !is_right && !is_down && is_up;
    end

endmodule

// File: design/lkd_core.sv
// lkd_core: key histories, stable and reported status, scan walk
// depends on lkd_pkg and lkd_classify
`timescale 1ns / 1ps

module lkd_core #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkd_pkg::lkd_cfg_t           cfg,
    input  lkd_pkg::lkd_item_t          item,
    output logic                        res_valid,
    output logic [lkd_pkg::CODE_W-1:0]  res_code
);
    import lkd_pkg::*;

    logic [HISTORY_BITS-1:0] ladder_hist_reg  [NUM_LADDER];
    logic [HISTORY_BITS-1:0] ladder_hist_next [NUM_LADDER];
    logic [HISTORY_BITS-1:0] ok_hist_reg;
    logic [HISTORY_BITS-1:0] ok_hist_next;
    logic [NUM_KEYS-1:0]     stable_reg;
    logic [NUM_KEYS-1:0]     stable_next;
    logic [NUM_KEYS-1:0]     reported_reg;
    logic [NUM_KEYS-1:0]     reported_next;
    logic [NUM_LADDER-1:0]   hit;
    logic                    found;

    lkd_classify u_classify (
        .cfg    (cfg),
        .sample (item.sample),
        .hit    (hit)
    );

    // history shift, settle and scan walk
    always_comb begin
        for (int i = 0; i < NUM_LADDER; i++) begin
            ladder_hist_next[i] = ladder_hist_reg[i];
        end
        ok_hist_next  = ok_hist_reg;
        stable_next   = stable_reg;
        reported_next = reported_reg;
        found         = 1'b0;
        res_valid     = 1'b0;
        res_code      = KEY_NONE;

        if (item.step) begin
            case (item.kind)
                KIND_SAMPLE: begin
                    for (int i = 0; i < NUM_LADDER; i++) begin
                        ladder_hist_next[i] = {ladder_hist_reg[i][HISTORY_BITS-2:0], hit[i]};
                        if (&ladder_hist_next[i]) begin
                            stable_next[i] = 1'b1;
                        end else if (~|ladder_hist_next[i]) begin
                            stable_next[i] = 1'b0;
                        end
                    end
                end
                KIND_TICK: begin
                    ok_hist_next = {ok_hist_reg[HISTORY_BITS-2:0], item.ok_level};
                    if (&ok_hist_next) begin
                        stable_next[NUM_KEYS-1] = 1'b1;
                    end else if (~|ok_hist_next) begin
                        stable_next[NUM_KEYS-1] = 1'b0;
                    end
                end
                KIND_SCAN: begin
                    res_valid = 1'b1;
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        if (!found && (reported_reg[i] != stable_reg[i])) begin
                            reported_next[i] = stable_reg[i];
                            if (stable_reg[i]) begin
                                found    = 1'b1;
                                res_code = CODE_W'(i + 1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LADDER; i++) begin
                ladder_hist_reg[i] <= '0;
            end
            ok_hist_reg  <= '0;
            stable_reg   <= '0;
            reported_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_LADDER; i++) begin
                ladder_hist_reg[i] <= ladder_hist_next[i];
            end
            ok_hist_reg  <= ok_hist_next;
            stable_reg   <= stable_next;
            reported_reg <= reported_next;
        end
    end

endmodule

// File: design/ladder_keypad_debounce_top.sv
// ladder_keypad_debounce_top: stream wrapper, threshold registers, input and result registers
// depends on lkd_pkg and lkd_core
`timescale 1ns / 1ps

// Debounced five-key pad: four keys on one resistor ladder read as 12-bit samples, one key on
// its own pin. Each request (tuser = kind) is a sample, an ok-pin tick or a scan; only a scan
// gives a result, the code of the first key newly pressed (1 left .. 5 ok) or 0. Every request
// passes through an input register, the combinational key logic and, for a scan, the result
// register; one request is taken per cycle while no scan waits; a scan result is registered
// as the scan advances. A scan request waits in the input register only while the result
// register still holds an untaken result. The user must write thresholds through the cfg
// port only while the block is idle, which the block does not enforce; index 7 is ignored.

module ladder_keypad_debounce_top #(
    parameter int HISTORY_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample, [12] ok_level, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] key_code, [7:3] zero
);
    import lkd_pkg::*;

    lkd_cfg_t            cfg_reg;
    logic                in_valid_reg;
    logic [1:0]          in_kind_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_ok_reg;
    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                advance;
    lkd_item_t           item;
    logic                res_valid;
    logic [CODE_W-1:0]   res_code;

    // threshold registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LEFT_MIN:   cfg_reg.left_min   <= cfg_data;
                REG_RIGHT_LOW:  cfg_reg.right_low  <= cfg_data;
                REG_RIGHT_HIGH: cfg_reg.right_high <= cfg_data;
                REG_DOWN_LOW:   cfg_reg.down_low   <= cfg_data;
                REG_DOWN_HIGH:  cfg_reg.down_high  <= cfg_data;
                REG_UP_LOW:     cfg_reg.up_low     <= cfg_data;
                REG_UP_HIGH:    cfg_reg.up_high    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a scan only proceeds once the result register can take its result
    assign advance  = in_valid_reg &&
                      !((in_kind_reg == KIND_SCAN) && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_ok_reg     <= s_tdata[SAMPLE_W];
        end
    end

    assign item = '{
        step:     advance,
        kind:     in_kind_reg,
        sample:   in_sample_reg,
        ok_level: in_ok_reg
    };

    lkd_core #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .item      (item),
        .res_valid (res_valid),
        .res_code  (res_code)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_code_reg <= res_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_code_reg};

endmodule

// File: verif/tb_ladder_keypad_debounce_top.sv
// tb_ladder_keypad_debounce_top: self-checking testbench for the ladder keypad debounce block
// tracks histories, stable and reported key states alongside the block and checks every scan code
// depends on lkd_pkg and ladder_keypad_debounce_top
`timescale 1ns / 1ps

module tb_ladder_keypad_debounce_top;

    import lkd_pkg::*;

    localparam int HIST_BITS      = 8;
    localparam int IDLE_PCT       = 28;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    // key positions, reported code is position plus one
    localparam int NO_KEY    = -1;
    localparam int KEY_LEFT  = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_DOWN  = 2;
    localparam int KEY_UP    = 3;
    localparam int KEY_OK    = 4;

    // kind value with no meaning, the block drops it
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // register index past the end of the list
    localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    // run control
    logic        no_idle    = 1'b0;
    int unsigned hold_asked = 0;
    int unsigned hold_given = 0;
    int unsigned hold_left  = 0;
    int          reqs_sent  = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    // shadow state of the keypad
    lkd_cfg_t             thr = CFG_RESET;
    logic [HIST_BITS-1:0] ladder_hist [NUM_LADDER] = '{default: '0};
    logic [HIST_BITS-1:0] ok_hist = '0;
    logic [NUM_KEYS-1:0]  stable_keys = '0;
    logic [NUM_KEYS-1:0]  reported_keys = '0;
    logic [CODE_W-1:0]    pending_codes [$];

    ladder_keypad_debounce_top #(
        .HISTORY_BITS(HIST_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- key tracking

    // ladder key that a sample selects, earlier key wins on overlap
    function automatic int ladder_key_of(logic [SAMPLE_W-1:0] smp);
        if (smp > thr.left_min) return KEY_LEFT;
        if (smp > thr.right_low && smp < thr.right_high) return KEY_RIGHT;
        if (smp > thr.down_low && smp < thr.down_high) return KEY_DOWN;
        if (smp > thr.up_low && smp < thr.up_high) return KEY_UP;
        return NO_KEY;
    endfunction

    function automatic void settle_key(int k, logic [HIST_BITS-1:0] h);
        if (&h) stable_keys[k] = 1'b1;
        else if (h == '0) stable_keys[k] = 1'b0;
    endfunction

    // advance the shadow state by one request, queue the code a scan reports
    function automatic void track_request(logic [1:0] kind, logic [SAMPLE_W-1:0] smp,
                                          logic okl);
        int                hit;
        logic              found;
        logic [CODE_W-1:0] code;
        case (kind)
            KIND_SAMPLE: begin
                hit = ladder_key_of(smp);
                for (int i = 0; i < NUM_LADDER; i++) begin
                    ladder_hist[i] = {ladder_hist[i][HIST_BITS-2:0], i == hit};
                    settle_key(i, ladder_hist[i]);
                end
            end
            KIND_TICK: begin
                ok_hist = {ok_hist[HIST_BITS-2:0], okl};
                settle_key(KEY_OK, ok_hist);
            end
            KIND_SCAN: begin
                code  = KEY_NONE;
                found = 1'b0;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (!found && reported_keys[i] != stable_keys[i]) begin
                        reported_keys[i] = stable_keys[i];
                        if (stable_keys[i]) begin
                            code  = CODE_W'(i + 1);
                            found = 1'b1;
                        end
                    end
                end
                pending_codes.push_back(code);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_threshold(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] v);
        case (idx)
            REG_LEFT_MIN:   thr.left_min   = v;
            REG_RIGHT_LOW:  thr.right_low  = v;
            REG_RIGHT_HIGH: thr.right_high = v;
            REG_DOWN_LOW:   thr.down_low   = v;
            REG_DOWN_HIGH:  thr.down_high  = v;
            REG_UP_LOW:     thr.up_low     = v;
            REG_UP_HIGH:    thr.up_high    = v;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- monitors

    // requests, results and register writes seen at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_codes.size() == 0) begin
                    report_mismatch("key code with no scan waiting", -1, m_tdata[CODE_W-1:0]);
                end else begin
                    if (m_tdata[CODE_W-1:0] !== pending_codes[0])
                        report_mismatch("key_code", pending_codes[0], m_tdata[CODE_W-1:0]);
                    void'(pending_codes.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                track_request(s_tuser, s_tdata[SAMPLE_W-1:0], s_tdata[SAMPLE_W]);
            if (cfg_valid && cfg_ready)
                apply_threshold(cfg_index, cfg_data);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_given != hold_asked) begin
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_given + 1;
        end
    end

    // result side ready
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_left != 0 || hold_given != hold_asked)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------- drivers

    function automatic int idle_gap();
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        return gap;
    endfunction

    // one request, returns at the edge it is taken
    task automatic send_req(logic [1:0] kind, logic [SAMPLE_W-1:0] smp, logic okl);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, okl, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind != KIND_UNUSED) reqs_sent++;
    endtask

    task automatic send_noise();
        send_req(2'($urandom_range(0, 3)), 12'($urandom), 1'($urandom));
    endtask

    task automatic send_scan();
        send_req(KIND_SCAN, 12'($urandom), 1'($urandom));
    endtask

    // stop sending and let every queued code and in-flight sample clear
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // only called with the block drained
    task automatic load_thresholds(lkd_cfg_t c, logic stray_write);
        write_reg(REG_LEFT_MIN,   c.left_min);
        write_reg(REG_RIGHT_LOW,  c.right_low);
        write_reg(REG_RIGHT_HIGH, c.right_high);
        write_reg(REG_DOWN_LOW,   c.down_low);
        write_reg(REG_DOWN_HIGH,  c.down_high);
        write_reg(REG_UP_LOW,     c.up_low);
        write_reg(REG_UP_HIGH,    c.up_high);
        if (stray_write) write_reg(REG_NONE, 12'hfff);
        cfg_valid <= 1'b0;
    endtask

    // a sample inside the key's window under the current thresholds, if it has one
    function automatic logic [SAMPLE_W-1:0] sample_for_key(int k);
        int lo, hi;
        case (k)
            KEY_LEFT:  begin lo = thr.left_min;  hi = 1 << SAMPLE_W;  end
            KEY_RIGHT: begin lo = thr.right_low; hi = thr.right_high; end
            KEY_DOWN:  begin lo = thr.down_low;  hi = thr.down_high;  end
            default:   begin lo = thr.up_low;    hi = thr.up_high;    end
        endcase
        if (hi - lo >= 2) return SAMPLE_W'($urandom_range(lo + 1, hi - 1));
        return SAMPLE_W'($urandom);
    endfunction

    function automatic lkd_cfg_t random_thresholds();
        lkd_cfg_t c;
        c.left_min   = 12'($urandom_range(2048, 4095));
        c.right_low  = 12'($urandom_range(0, 4000));
        c.right_high = 12'($urandom_range(c.right_low, 4095));
        c.down_low   = 12'($urandom_range(0, 4000));
        c.down_high  = 12'($urandom_range(c.down_low, 4095));
        c.up_low     = 12'($urandom_range(0, 4000));
        c.up_high    = 12'($urandom_range(c.up_low, 4095));
        return c;
    endfunction

    // mostly held presses and releases with scans between, some noise
    task automatic run_random(int n_reqs);
        int first, pick, k, len;
        first = reqs_sent;
        while (reqs_sent - first < n_reqs) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // hold one key, often long enough to settle, with the odd bounce
                k   = $urandom_range(KEY_LEFT, KEY_OK);
                len = $urandom_range(5, 12);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 12)
                        send_noise();
                    else if (k == KEY_OK)
                        send_req(KIND_TICK, 12'($urandom), 1'b1);
                    else
                        send_req(KIND_SAMPLE, sample_for_key(k), 1'($urandom));
                end
                if ($urandom_range(0, 99) < 70) send_scan();
            end else if (pick < 70) begin
                // release: sample 0 matches no key, ok pin low
                len = $urandom_range(6, 10);
                if ($urandom_range(0, 1) == 0) begin
                    repeat (len) send_req(KIND_TICK, 12'($urandom), 1'b0);
                end else begin
                    repeat (len)
                        send_req(KIND_SAMPLE,
                                 ($urandom_range(0, 3) == 0) ? 12'($urandom) : '0,
                                 1'($urandom));
                end
            end else if (pick < 88) begin
                send_scan();
            end else if (pick < 95) begin
                send_noise();
            end else begin
                repeat ($urandom_range(2, 5)) send_scan();
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset thresholds: window edges, unused kind, left and ok presses
    task automatic test_directed_defaults();
        send_scan();
        send_req(KIND_UNUSED, 12'hfff, 1'b1);
        send_req(KIND_SAMPLE, 12'd0, 1'b1);
        send_req(KIND_SAMPLE, CFG_RESET.left_min, 1'b0);
        send_req(KIND_SAMPLE, CFG_RESET.right_low, 1'b1);
        send_req(KIND_SAMPLE, CFG_RESET.down_high, 1'b0);
        repeat (HIST_BITS) send_req(KIND_SAMPLE, 12'hfff, 1'b1);
        repeat (HIST_BITS) send_req(KIND_TICK, 12'($urandom), 1'b1);
        repeat (3) send_scan();
    endtask

    task automatic test_random_defaults();
        run_random(300);
    endtask

    // all thresholds zero: every non-zero sample is left, windows empty; no idling here
    task automatic test_low_extremes();
        wait_drained();
        load_thresholds('0, 1'b1);
        no_idle <= 1'b1;
        run_random(200);
        no_idle <= 1'b0;
    endtask

    // left never hit, right and down span the range and overlap, up empty
    task automatic test_high_extremes();
        lkd_cfg_t c;
        c = '{left_min: 12'hfff, right_low: 12'h000, right_high: 12'hfff,
              down_low: 12'h000, down_high: 12'hfff, up_low: 12'hfff, up_high: 12'hfff};
        wait_drained();
        load_thresholds(c, 1'b0);
        run_random(200);
    endtask

    task automatic test_random_thresholds();
        repeat (2) begin
            wait_drained();
            load_thresholds(random_thresholds(), 1'b0);
            run_random(200);
        end
    endtask

    // receiver stalls while scans keep coming, so the input side backs up
    task automatic test_backpressure();
        wait_drained();
        load_thresholds(CFG_RESET, 1'b0);
        no_idle    <= 1'b1;
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 48; i++) begin
            if (i % 3 == 0) send_scan();
            else send_req(KIND_SAMPLE, sample_for_key($urandom_range(KEY_LEFT, KEY_UP)), 1'b0);
        end
        no_idle <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_defaults();
        test_random_defaults();
        test_low_extremes();
        test_high_extremes();
        test_random_thresholds();
        test_backpressure();
        wait_drained();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
